>>> rtl/core/dsbs_pkg.sv
// Shared types and constants for the depth sensor bus slave.
// No dependencies; dsbs_front, dsbs_queue, dsbs_back and the top import this package.
package dsbs_pkg;

  localparam int unsigned SAMPLE_MAX_W = 16;
  localparam int unsigned AVG_W        = 16;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned ID_REPLY_LEN = 7;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  localparam logic [7:0] CMD_PING      = 8'd0;
  localparam logic [7:0] CMD_IDENT     = 8'd1;
  localparam logic [7:0] CMD_REG_READ  = 8'd2;
  localparam logic [7:0] CMD_REG_WRITE = 8'd3;
  localparam logic [7:0] CMD_SPEED0    = 8'd4;
  localparam logic [7:0] CMD_SPEED1    = 8'd5;
  localparam logic [7:0] CMD_RELAY_ON  = 8'd6;
  localparam logic [7:0] CMD_RELAY_OFF = 8'd7;
  localparam logic [7:0] CMD_DEPTH     = 8'd8;

  localparam logic [2:0] ST_TOP    = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_WRITE  = 3'd2;
  localparam logic [2:0] ST_SPEED0 = 3'd4;
  localparam logic [2:0] ST_SPEED1 = 3'd5;

  localparam logic [7:0] REPLY_PING   = 8'd0;
  localparam logic [7:0] REPLY_REG    = 8'd1;
  localparam logic [7:0] REPLY_DEPTHV = 8'd2;
  localparam logic [7:0] REG_RESET    = 8'd65;
  localparam logic [AVG_W-1:0] AVG_RESET = 16'h1234;
  localparam logic [3:0] BATCH_LAST   = 4'd15;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_READ,
    KIND_SAMPLE,
    KIND_NOP
  } kind_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] bus_data;
    logic [9:0] sample;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       relay_on;
    logic       speed_valid;
    logic       speed_port;
    logic [7:0] speed_first;
    logic [7:0] speed_second;
  } out_t;

  typedef struct packed {
    kind_e                   kind;
    logic [7:0]              data;
    logic [SAMPLE_MAX_W-1:0] sample;
  } req_t;

  // identify reply: length, then the name text, then a terminator
  function automatic logic [7:0] id_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = 8'd5;
      3'd1:    b = 8'h44;
      3'd2:    b = 8'h65;
      3'd3:    b = 8'h70;
      3'd4:    b = 8'h74;
      3'd5:    b = 8'h68;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/core/dsbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dsbs_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/dsbs_front.sv
// Front end: takes input requests and classifies them for the queue.
// Depends on dsbs_pkg.
module dsbs_front #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  dsbs_pkg::in_t  in_req_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output dsbs_pkg::req_t q_req_o
);
  import dsbs_pkg::*;

  localparam logic [SAMPLE_MAX_W-1:0] SMP_MASK =
    SAMPLE_MAX_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  kind_e kind;

  always_comb begin
    case (in_req_i.opcode)
      OP_WRITE:  kind = KIND_WRITE;
      OP_READ:   kind = KIND_READ;
      OP_SAMPLE: kind = KIND_SAMPLE;
      default:   kind = KIND_NOP;
    endcase
  end

  assign in_stall_o      = q_full_i;
  assign q_push_o        = in_valid_i && !q_full_i;
  assign q_req_o.kind    = kind;
  assign q_req_o.data    = in_req_i.bus_data;
  assign q_req_o.sample  = SAMPLE_MAX_W'(in_req_i.sample) & SMP_MASK;

endmodule

>>> rtl/core/dsbs_queue.sv
// Short request queue between front and back ends.
// Depends on dsbs_pkg.
module dsbs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dsbs_pkg::req_t req_i,
  input  logic           pop_i,
  output logic           valid_o,
  output logic           full_o,
  output dsbs_pkg::req_t req_o
);
  import dsbs_pkg::*;

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  req_t             slot_q [QUEUE_DEPTH];
  logic [IDX_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign req_o   = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= req_i;
    end
  end

endmodule

>>> rtl/core/dsbs_back.sv
// Back end: command machine, reply buffer, settings, depth averager, result register.
// Depends on dsbs_pkg and dsbs_ram.
module dsbs_back #(
  parameter int unsigned REPLY_DEPTH = 8,
  parameter int unsigned AVG_WINDOW  = 128,
  parameter int unsigned REG_COUNT   = 16,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  dsbs_pkg::req_t q_req_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dsbs_pkg::out_t out_req_o
);
  import dsbs_pkg::*;

  localparam int unsigned PTR_W     = $clog2(REPLY_DEPTH + 1);
  localparam int unsigned RIDX_W    = $clog2(REPLY_DEPTH);
  localparam int unsigned REG_W     = $clog2(REG_COUNT);
  localparam int unsigned RING_W    = $clog2(AVG_WINDOW);
  localparam int unsigned SUM_W     = SAMPLE_BITS + RING_W;
  localparam int unsigned DIV_SHIFT = SUM_W + RING_W;
  localparam int unsigned RECIP_W   = SUM_W + 1;
  localparam int unsigned PROD_W    = SUM_W + RECIP_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << DIV_SHIFT) + AVG_WINDOW - 1) / AVG_WINDOW;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  logic [2:0]             state_q, state_d;
  logic                   argc_q, argc_d;
  logic [7:0]             first_q, first_d;
  logic [7:0]             regs_q [REG_COUNT];
  logic [7:0]             regs_d [REG_COUNT];
  logic [7:0]             reply_q [REPLY_DEPTH];
  logic [7:0]             reply_d [REPLY_DEPTH];
  logic [PTR_W-1:0]       ptr_q, ptr_d;
  logic                   relay_q, relay_d;
  logic [RING_W-1:0]      ring_idx_q, ring_idx_d;
  logic                   wrapped_q, wrapped_d;
  logic [3:0]             batch_q, batch_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [AVG_W-1:0]       avg_q;
  logic                   avg_pend_q, avg_pend_d;
  logic                   out_valid_q;
  out_t                   out_q, res;
  logic [REG_W-1:0]       reg_map [256];
  logic [PROD_W-1:0]      prod;
  logic [AVG_W-1:0]       avg_now;
  logic [SAMPLE_BITS-1:0] smp;
  logic [SAMPLE_BITS-1:0] ring_rd, ring_old;
  logic                   ring_we;
  logic                   pop;
  logic [7:0]             d;

  always_comb begin
    for (int k = 0; k < 256; k++) begin
      reg_map[k] = REG_W'(k % REG_COUNT);
    end
  end

  // sum / AVG_WINDOW by reciprocal multiply, exact for every reachable sum
  assign prod    = PROD_W'(sum_q) * PROD_W'(RECIP);
  assign avg_now = avg_pend_q ? AVG_W'(prod[DIV_SHIFT +: SAMPLE_BITS]) : avg_q;

  assign pop      = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o  = pop;
  assign d        = q_req_i.data;
  assign smp      = SAMPLE_BITS'(q_req_i.sample);
  assign ring_old = wrapped_q ? ring_rd : '0;
  assign ring_we  = pop && (q_req_i.kind == KIND_SAMPLE);

  always_comb begin
    state_d    = state_q;
    argc_d     = argc_q;
    first_d    = first_q;
    regs_d     = regs_q;
    reply_d    = reply_q;
    ptr_d      = ptr_q;
    relay_d    = relay_q;
    ring_idx_d = ring_idx_q;
    wrapped_d  = wrapped_q;
    batch_d    = batch_q;
    sum_d      = sum_q;
    avg_pend_d = 1'b0;
    res        = '0;
    if (pop) begin
      case (q_req_i.kind)
        KIND_WRITE: begin
          ptr_d = '0;
          case (state_q)
            ST_TOP: begin
              case (d)
                CMD_PING: reply_d[0] = REPLY_PING;
                CMD_IDENT: begin
                  for (int k = 0; k < REPLY_DEPTH; k++) begin
                    if (k < ID_REPLY_LEN) begin
                      reply_d[k] = id_byte(3'(k));
                    end
                  end
                end
                CMD_REG_READ: begin
                  state_d = ST_READ;
                  argc_d  = 1'b0;
                end
                CMD_REG_WRITE: begin
                  state_d = ST_WRITE;
                  argc_d  = 1'b0;
                end
                CMD_SPEED0: begin
                  state_d = ST_SPEED0;
                  argc_d  = 1'b0;
                end
                CMD_SPEED1: begin
                  state_d = ST_SPEED1;
                  argc_d  = 1'b0;
                end
                CMD_RELAY_ON:  relay_d = 1'b1;
                CMD_RELAY_OFF: relay_d = 1'b0;
                CMD_DEPTH: begin
                  reply_d[0] = REPLY_DEPTHV;
                  reply_d[1] = avg_now[15:8];
                  reply_d[2] = avg_now[7:0];
                end
                default: ;
              endcase
            end
            ST_READ: begin
              argc_d     = 1'b0;
              state_d    = ST_TOP;
              reply_d[0] = REPLY_REG;
              reply_d[1] = regs_q[reg_map[d]];
            end
            ST_WRITE: begin
              if (!argc_q) begin
                first_d = d;
                argc_d  = 1'b1;
              end else begin
                argc_d                  = 1'b0;
                state_d                 = ST_TOP;
                regs_d[reg_map[first_q]] = d;
              end
            end
            ST_SPEED0, ST_SPEED1: begin
              if (!argc_q) begin
                first_d = d;
                argc_d  = 1'b1;
              end else begin
                argc_d           = 1'b0;
                state_d          = ST_TOP;
                res.speed_valid  = 1'b1;
                res.speed_port   = (state_q == ST_SPEED1);
                res.speed_first  = first_q;
                res.speed_second = d;
              end
            end
            default: begin
              state_d = ST_TOP;
              argc_d  = 1'b0;
            end
          endcase
        end
        KIND_READ: begin
          if (ptr_q < PTR_W'(REPLY_DEPTH)) begin
            res.read_data = reply_q[ptr_q[RIDX_W-1:0]];
            ptr_d         = ptr_q + 1'b1;
          end
        end
        KIND_SAMPLE: begin
          sum_d = sum_q - SUM_W'(ring_old) + SUM_W'(smp);
          if (ring_idx_q == RING_W'(AVG_WINDOW - 1)) begin
            ring_idx_d = '0;
            wrapped_d  = 1'b1;
          end else begin
            ring_idx_d = ring_idx_q + 1'b1;
          end
          batch_d = batch_q + 1'b1;
          if (batch_q == BATCH_LAST) begin
            avg_pend_d = 1'b1;
          end
        end
        default: ;
      endcase
      res.relay_on = relay_d;
    end
  end

  dsbs_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(AVG_WINDOW)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(ring_idx_q),
    .wdata_i(smp),
    .raddr_i(ring_idx_d),
    .rdata_o(ring_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_TOP;
      argc_q      <= 1'b0;
      first_q     <= '0;
      regs_q      <= '{default: REG_RESET};
      reply_q     <= '{default: 8'h00};
      ptr_q       <= '0;
      relay_q     <= 1'b1;
      ring_idx_q  <= '0;
      wrapped_q   <= 1'b0;
      batch_q     <= '0;
      sum_q       <= '0;
      avg_q       <= AVG_RESET;
      avg_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      argc_q     <= argc_d;
      first_q    <= first_d;
      regs_q     <= regs_d;
      reply_q    <= reply_d;
      ptr_q      <= ptr_d;
      relay_q    <= relay_d;
      ring_idx_q <= ring_idx_d;
      wrapped_q  <= wrapped_d;
      batch_q    <= batch_d;
      sum_q      <= sum_d;
      avg_q      <= avg_now;
      avg_pend_q <= avg_pend_d;
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PTR_W'(REPLY_DEPTH))
    else $error("reply pointer past buffer end");

  a_argc_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    argc_q |-> (state_q == ST_WRITE || state_q == ST_SPEED0 || state_q == ST_SPEED1))
    else $error("argument count set outside a two-byte command");

  a_speed_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && res.speed_valid) |=> (state_q == ST_TOP && !argc_q))
    else $error("speed set did not return to top level");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !pop)
    else $error("result register overwritten while stalled");

endmodule

>>> rtl/core/depth_sensor_bus_slave_top.sv
// Depth sensor bus slave: front end, request queue and back end.
// Depends on dsbs_pkg, dsbs_front, dsbs_queue, dsbs_back and dsbs_ram.
//
// Each request (master byte write, master byte read or converter sample) yields
// one result. The front end takes a request every cycle while the two-entry queue
// has room; the back end retires one request per cycle into a result register
// unless a held result is stalled, so the sustained rate is one request per cycle
// while not stalled. Sample history sits in an AVG_WINDOW-entry RAM read
// ahead of use; every 16th sample reloads the depth average (window sum / window).
module depth_sensor_bus_slave_top #(
  parameter int unsigned REPLY_DEPTH = 8,
  parameter int unsigned AVG_WINDOW  = 128,
  parameter int unsigned REG_COUNT   = 16,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  dsbs_pkg::in_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dsbs_pkg::out_t out_req_o
);
  import dsbs_pkg::*;

  req_t front_req, queue_req;
  logic push, pop, q_full, q_valid;

  dsbs_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_req_i  (in_req_i),
    .q_full_i  (q_full),
    .q_push_o  (push),
    .q_req_o   (front_req)
  );

  dsbs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .req_i  (front_req),
    .pop_i  (pop),
    .valid_o(q_valid),
    .full_o (q_full),
    .req_o  (queue_req)
  );

  dsbs_back #(
    .REPLY_DEPTH(REPLY_DEPTH),
    .AVG_WINDOW (AVG_WINDOW),
    .REG_COUNT  (REG_COUNT),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_req_i    (queue_req),
    .q_pop_o    (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

endmodule
